FILE: rtl/core/rsadlm_pkg.sv
// Shared types and constants for the RSA decrypt letter map block.
`timescale 1ns / 1ps
package rsadlm_pkg;
    localparam logic [7:0] LETTER_BASE = 8'd65;
    localparam logic [7:0] SPACE_CODE  = 8'd32;
    localparam int unsigned SPACE_VALUE = 28;

    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_EXPONENT = 2'd1;
    localparam logic [1:0] REG_OFFSET   = 2'd2;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_REDUCE,
        t_ST_SQUARE,
        t_ST_MULT,
        t_ST_DONE
    } t_state;

    // Control from the sequencer to the multiplier chain.
    typedef struct packed {
        logic start;
        logic busy;
    } t_mul_ctrl;
endpackage

FILE: rtl/core/rsadlm_cell.sv
// One cell of the modular multiplier chain: double-and-add step with reduction.
`timescale 1ns / 1ps
module rsadlm_cell
    import rsadlm_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_acc,
    input  logic             i_bit,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_acc
);
    logic [WIDTH:0]   w_dbl;
    logic [WIDTH-1:0] w_r1;
    logic [WIDTH:0]   w_add;
    logic [WIDTH-1:0] n_acc;
    logic             r_valid;
    logic [WIDTH-1:0] r_acc;

    // Double then conditionally add, each reduced once below m.
    always_comb begin
        w_dbl = {i_acc, 1'b0};
        w_r1  = (w_dbl >= {1'b0, i_m}) ? WIDTH'(w_dbl - {1'b0, i_m}) : w_dbl[WIDTH-1:0];
        w_add = {1'b0, w_r1} + {1'b0, i_a};
        if (!i_bit) begin
            n_acc = w_r1;
        end else if (w_add >= {1'b0, i_m}) begin
            n_acc = WIDTH'(w_add - {1'b0, i_m});
        end else begin
            n_acc = w_add[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_acc <= n_acc;
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
endmodule

FILE: rtl/core/rsadlm_mulchain.sv
// Modular multiplier built as a row of cells, one multiplier bit per cell.
`timescale 1ns / 1ps
module rsadlm_mulchain
    import rsadlm_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_ctrl        i_ctrl,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_prod
);
    logic [WIDTH:0]   w_valid;
    logic [WIDTH-1:0] w_acc [WIDTH+1];
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_m;

    // Hold operands for the pass through the chain.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
        end
    end

    logic r_go;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_ctrl.start;
        end
    end

    assign w_valid[0] = r_go;
    assign w_acc[0]   = '0;

    // Cell k handles multiplier bit WIDTH-1-k, most significant first.
    for (genvar k = 0; k < WIDTH; k++) begin : g_cell
        rsadlm_cell #(.WIDTH(WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_acc   (w_acc[k]),
            .i_bit   (r_b[WIDTH-1-k]),
            .i_a     (r_a),
            .i_m     (r_m),
            .o_valid (w_valid[k+1]),
            .o_acc   (w_acc[k+1])
        );
    end

    assign o_done = w_valid[WIDTH] & i_ctrl.busy;
    assign o_prod = w_acc[WIDTH];
endmodule

FILE: rtl/core/rsa_decrypt_letter_map.sv
// Top level: square-and-multiply sequencer around the modular multiplier chain.
//
//  channel   dir  handshake             payload
//  s_axis    in   i_s_axis_tvalid/ready cipher_value
//  m_axis    out  o_m_axis_tvalid/ready plain_value, char_code
//  config    in   i_cfg_we              index, data
//
// Each item reduces the cipher modulo the modulus, then runs WIDTH squarings plus one
// multiplication per set exponent bit, each a pass through the chain, and then loads
// the result; the total time is set by the exponent.
// A zero modulus skips straight to the result. Reset is synchronous and loads
// the register defaults. A stalled result holds in the output register and a
// new item is accepted only once it has been taken.
`timescale 1ns / 1ps
module rsa_decrypt_letter_map
    import rsadlm_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [((WIDTH+7)/8)*8-1:0] i_s_axis_tdata, // cipher_value
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [((WIDTH+15)/8)*8-1:0] o_m_axis_tdata, // plain_value, char_code
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [WIDTH-1:0] i_cfg_data
);
    localparam int CW = $clog2(WIDTH);
    localparam int OW = ((WIDTH + 15) / 8) * 8;

    logic [WIDTH-1:0] r_mod, r_exp;
    logic [7:0]       r_ofs;
    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_base, r_res, r_rem;
    logic [WIDTH-1:0] r_cin;
    logic [CW-1:0]    r_cnt;
    logic             r_ovalid;
    logic [WIDTH-1:0] r_plain;
    logic [7:0]       r_code;

    t_mul_ctrl        w_ctrl;
    logic             w_done;
    logic [WIDTH-1:0] w_prod;
    logic [WIDTH-1:0] w_ma, w_mb;
    logic             w_acc_in;
    logic             w_last;
    logic [WIDTH:0]   w_rd;
    logic [7:0]       w_code;

    assign w_acc_in = i_s_axis_tvalid & o_s_axis_tready;
    assign w_last   = (r_cnt == CW'(0));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WIDTH'(55);
            r_exp <= WIDTH'(7);
            r_ofs <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODULUS:  r_mod <= i_cfg_data;
                REG_EXPONENT: r_exp <= i_cfg_data;
                REG_OFFSET:   r_ofs <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_IDLE:   if (w_acc_in) n_state = t_ST_REDUCE;
            t_ST_REDUCE: if (w_last) n_state = t_ST_SQUARE;
            t_ST_SQUARE: if (w_done) n_state = r_exp[r_cnt] ? t_ST_MULT :
                                     (w_last ? t_ST_DONE : t_ST_SQUARE);
            t_ST_MULT:   if (w_done) n_state = w_last ? t_ST_DONE : t_ST_SQUARE;
            t_ST_DONE:   n_state = t_ST_IDLE;
            default:     n_state = t_ST_IDLE;
        endcase
        if (r_state == t_ST_REDUCE && r_mod == '0) n_state = t_ST_DONE;
    end

    // Multiplier control and operands.
    always_comb begin
        w_ctrl.busy  = (r_state == t_ST_SQUARE) || (r_state == t_ST_MULT);
        w_ctrl.start = ((r_state == t_ST_REDUCE) && w_last && r_mod != '0) ||
                       (w_ctrl.busy && w_done && n_state != t_ST_DONE);
        w_ma = r_res;
        w_mb = r_res;
        if (r_state == t_ST_REDUCE) begin
            w_ma = {{(WIDTH-1){1'b0}}, (r_mod != WIDTH'(1))};
            w_mb = w_ma;
        end else if (w_ctrl.busy && w_done) begin
            w_ma = w_prod;
            w_mb = (r_state == t_ST_SQUARE && r_exp[r_cnt]) ? r_base : w_prod;
        end
    end

    rsadlm_mulchain #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_m     (r_mod),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    // Restoring remainder step for c mod n, one cipher bit per cycle.
    assign w_rd = {r_rem, r_cin[WIDTH-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc_in) begin
                r_cnt <= CW'(WIDTH - 1);
            end else if (r_state == t_ST_REDUCE) begin
                r_cnt <= w_last ? CW'(WIDTH - 1) : r_cnt - CW'(1);
            end else if (r_state == t_ST_MULT && w_done) begin
                r_cnt <= r_cnt - CW'(1);
            end else if (r_state == t_ST_SQUARE && w_done && !r_exp[r_cnt]) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (w_acc_in) begin
            r_cin <= i_s_axis_tdata[WIDTH-1:0];
            r_rem <= '0;
            r_res <= '0;
        end else if (r_state == t_ST_REDUCE) begin
            r_cin <= {r_cin[WIDTH-2:0], 1'b0};
            r_rem <= (w_rd >= {1'b0, r_mod}) ? WIDTH'(w_rd - {1'b0, r_mod}) : w_rd[WIDTH-1:0];
            if (w_last) begin
                r_base <= (w_rd >= {1'b0, r_mod}) ? WIDTH'(w_rd - {1'b0, r_mod})
                                                  : w_rd[WIDTH-1:0];
                r_res  <= w_ma;
            end
        end else if (w_ctrl.busy && w_done) begin
            r_res <= w_prod;
        end
    end

    // Letter code of the final value.
    always_comb begin
        if (r_res == WIDTH'(SPACE_VALUE)) begin
            w_code = SPACE_CODE;
        end else begin
            w_code = r_res[7:0] + LETTER_BASE - r_ofs;
        end
    end

    // Output register: hold until the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == t_ST_DONE) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (r_state == t_ST_DONE) begin
            r_plain <= (r_mod == '0) ? '0 : r_res;
            r_code  <= (r_mod == '0) ? (LETTER_BASE - r_ofs) : w_code;
        end
    end

    assign o_s_axis_tready = (r_state == t_ST_IDLE) && !r_ovalid;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OW'({r_code, r_plain});

`ifndef NO_ASSERTIONS
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !o_s_axis_tready) else $error("accepted with result pending");
    a_res_lt_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.busy && w_done) |-> (w_prod < r_mod)) else $error("product not reduced");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_ST_DONE) |=> r_ovalid) else $error("result lost");
`endif
endmodule
